### rtl/aminv_pkg.sv
package aminv_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 4;
   localparam int ELEM_COUNT  = 12;
   localparam int ADJ_COUNT   = 9;
   localparam int LAST_INDEX  = 11;
   localparam int ADJ_W       = 64;
   localparam int PROD_W      = 66;
   localparam int ACC_W       = 98;
   localparam int MAG_W       = ACC_W - 1;
   localparam int NUM_W       = ADJ_W + 2 * FRAC_BITS;
   localparam int DIV_CNT_W   = $clog2(NUM_W);
   localparam int EPS_W       = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_W  = 2;

   localparam logic [CSR_ADDR_W-1:0] REG_SINGULAR_EPSILON = 2'd0;
   localparam logic [EPS_W-1:0]      EPS_RESET            = 16'd1;

   localparam logic [1:0] PH_ADDR = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_ACC  = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [INDEX_W-1:0]        index_type;

   typedef struct packed {
      value_type value;
      index_type index;
      logic      start;
   } elem_type;

   typedef struct packed {
      index_type a;
      index_type b;
   } pair_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ADJ,
      BK_DET,
      BK_CHECK,
      BK_DIV,
      BK_TRN,
      BK_EMIT
   } back_state_type;

   // Element pairs of the two cofactor products; the second one is subtracted.
   function automatic pair_type adj_pair(input index_type k, input logic t);
      pair_type p;
      p = '{a: 4'd0, b: 4'd0};
      unique case ({k, t})
         {4'd0, 1'b0}: p = '{a: 4'd4, b: 4'd8};
         {4'd0, 1'b1}: p = '{a: 4'd5, b: 4'd7};
         {4'd1, 1'b0}: p = '{a: 4'd2, b: 4'd7};
         {4'd1, 1'b1}: p = '{a: 4'd1, b: 4'd8};
         {4'd2, 1'b0}: p = '{a: 4'd1, b: 4'd5};
         {4'd2, 1'b1}: p = '{a: 4'd2, b: 4'd4};
         {4'd3, 1'b0}: p = '{a: 4'd5, b: 4'd6};
         {4'd3, 1'b1}: p = '{a: 4'd3, b: 4'd8};
         {4'd4, 1'b0}: p = '{a: 4'd0, b: 4'd8};
         {4'd4, 1'b1}: p = '{a: 4'd2, b: 4'd6};
         {4'd5, 1'b0}: p = '{a: 4'd2, b: 4'd3};
         {4'd5, 1'b1}: p = '{a: 4'd0, b: 4'd5};
         {4'd6, 1'b0}: p = '{a: 4'd3, b: 4'd7};
         {4'd6, 1'b1}: p = '{a: 4'd4, b: 4'd6};
         {4'd7, 1'b0}: p = '{a: 4'd1, b: 4'd6};
         {4'd7, 1'b1}: p = '{a: 4'd0, b: 4'd7};
         {4'd8, 1'b0}: p = '{a: 4'd0, b: 4'd4};
         {4'd8, 1'b1}: p = '{a: 4'd1, b: 4'd3};
         default:      p = '{a: 4'd0, b: 4'd0};
      endcase
      return p;
   endfunction

endpackage

### rtl/aminv_if.sv
interface aminv_req_if;
   import aminv_pkg::*;
   logic      valid;
   logic      ready;
   value_type elem_value;
   index_type elem_index;
   modport source (output valid, output elem_value, output elem_index, input ready);
   modport sink (input valid, input elem_value, input elem_index, output ready);
endinterface

interface aminv_rsp_if;
   import aminv_pkg::*;
   logic      valid;
   logic      ready;
   value_type out_value;
   index_type out_index;
   logic      singular;
   logic      last;
   modport source (output valid, output out_value, output out_index, output singular,
                   output last, input ready);
   modport sink (input valid, input out_value, input out_index, input singular,
                 input last, output ready);
endinterface

### rtl/aminv_front.sv
module aminv_front (
   aminv_req_if.sink             req,
   output logic                  push_valid,
   input  logic                  push_ready,
   output aminv_pkg::elem_type   push_data
);
   import aminv_pkg::*;

   logic in_range;

   // Beats with an index past the element file are taken and dropped.
   assign in_range   = req.elem_index <= index_type'(LAST_INDEX);
   assign req.ready  = push_ready;
   assign push_valid = req.valid && in_range;

   always_comb begin
      push_data.value = req.elem_value;
      push_data.index = req.elem_index;
      push_data.start = req.elem_index == index_type'(LAST_INDEX);
   end

endmodule

### rtl/aminv_queue.sv
module aminv_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  aminv_pkg::elem_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output aminv_pkg::elem_type pop_data
);
   import aminv_pkg::*;

   elem_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/aminv_back.sv
module aminv_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  aminv_pkg::elem_type            pop_data,
   input  logic [aminv_pkg::EPS_W-1:0]    epsilon,
   aminv_rsp_if.source                    rsp
);
   import aminv_pkg::*;

   function automatic value_type sat_value(input logic neg, input logic ovf,
                                           input logic [32:0] mag);
      logic [32:0] lim;
      lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      if (ovf || mag > lim) begin
         return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return neg ? value_type'(-mag[31:0]) : value_type'(mag[31:0]);
   endfunction

   back_state_type              state_ff, state_in;
   index_type                   step_ff, step_in;
   logic [1:0]                  term_ff, term_in;
   logic [1:0]                  phase_ff, phase_in;

   value_type                   elem_mem [ELEM_COUNT];
   value_type                   rd_a_ff, rd_b_ff;
   index_type                   addr_a, addr_b;
   pair_type                    pair;

   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [32:0]          op_a, op_b;
   logic signed [ACC_W-1:0]     acc_ff, acc_sum, prod_ext, addend;
   logic signed [ADJ_W-1:0]     adj_ff [ADJ_COUNT];
   index_type                   adj_sel;
   logic signed [ADJ_W-1:0]     adj_rd;
   value_type                   res_ff [ELEM_COUNT];
   index_type                   res_sel;
   value_type                   res_rd;

   logic                        det_neg_ff;
   logic [MAG_W-1:0]            det_mag_ff;
   logic                        sing_ff, sing_now;

   logic [NUM_W-1:0]            num_ff;
   logic [MAG_W-1:0]            rem_ff;
   logic [MAG_W:0]              rem_sh, rem_next;
   logic [32:0]                 quo_ff, quo_next;
   logic                        ovf_ff, ovf_next, div_neg_ff, div_ge;
   logic [DIV_CNT_W-1:0]        cnt_ff;
   logic [ADJ_W-1:0]            adj_abs;

   logic signed [ACC_W-1:0]     trn_mag;
   logic                        trn_neg;
   logic [ACC_W-1:0]            trn_shr;
   value_type                   trn_value, div_value;

   logic                        mul_en, acc_en, acc_clr, acc_done;
   logic                        last_term, sub_term, hi_term;
   logic                        adj_we, det_we, res_we, div_load, div_step, out_load;
   index_type                   res_widx;
   value_type                   res_wdata;

   logic                        out_valid_ff;
   value_type                   out_value_ff;
   index_type                   out_index_ff;
   logic                        out_sing_ff, out_last_ff;

   // Operand addresses and read selects for the shared multiplier.
   always_comb begin
      pair    = adj_pair(step_ff, term_ff[0]);
      addr_a  = pair.a;
      addr_b  = pair.b;
      adj_sel = step_ff;
      res_sel = step_ff;
      unique case (state_ff)
         BK_DET: begin
            addr_a  = step_ff;
            adj_sel = index_type'(3 * step_ff);
         end
         BK_TRN: begin
            addr_a  = index_type'(LAST_INDEX - 2) + index_type'(term_ff);
            res_sel = index_type'(3 * term_ff) + step_ff;
         end
         BK_CHECK: adj_sel = '0;
         BK_DIV:   adj_sel = (step_ff == index_type'(ADJ_COUNT - 1)) ? '0 : step_ff + 1'b1;
         default: begin
         end
      endcase
   end

   assign adj_rd = adj_ff[adj_sel];
   assign res_rd = res_ff[res_sel];

   always_comb begin
      op_a = {rd_a_ff[VALUE_W-1], rd_a_ff};
      op_b = {rd_b_ff[VALUE_W-1], rd_b_ff};
      if (state_ff == BK_DET) begin
         // Adjugate split into an unsigned low word and a signed high word.
         op_b = term_ff[0] ? {adj_rd[ADJ_W-1], adj_rd[ADJ_W-1:32]} : {1'b0, adj_rd[31:0]};
      end else if (state_ff == BK_TRN) begin
         op_b = {res_rd[VALUE_W-1], res_rd};
      end
   end

   assign sub_term  = (state_ff == BK_ADJ) && term_ff[0];
   assign hi_term   = (state_ff == BK_DET) && term_ff[0];
   assign last_term = (state_ff == BK_TRN) ? (term_ff == 2'd2) : term_ff[0];
   assign prod_ext  = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign addend    = hi_term ? (prod_ext <<< 32) : prod_ext;
   assign acc_sum   = sub_term ? acc_ff - addend : acc_ff + addend;

   // Translation: the negated sum is negative exactly when the sum is positive;
   // its magnitude is truncated toward zero and saturated.
   always_comb begin
      trn_neg   = !acc_sum[ACC_W-1] && (acc_sum != '0);
      trn_mag   = acc_sum[ACC_W-1] ? -acc_sum : acc_sum;
      trn_shr   = trn_mag >> FRAC_BITS;
      trn_value = sat_value(trn_neg, |trn_shr[ACC_W-1:33], trn_shr[32:0]);
   end

   // One restoring division step per cycle.
   always_comb begin
      rem_sh    = {rem_ff, num_ff[NUM_W-1]};
      div_ge    = rem_sh >= {1'b0, det_mag_ff};
      rem_next  = div_ge ? rem_sh - {1'b0, det_mag_ff} : rem_sh;
      quo_next  = {quo_ff[31:0], div_ge};
      ovf_next  = ovf_ff | quo_ff[32];
      div_value = sat_value(div_neg_ff, ovf_next, quo_next);
      adj_abs   = adj_rd[ADJ_W-1] ? ADJ_W'(-adj_rd) : ADJ_W'(adj_rd);
   end

   assign sing_now = det_mag_ff <= (MAG_W'(epsilon) << (2 * FRAC_BITS));

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      term_in   = term_ff;
      phase_in  = phase_ff;
      pop_ready = 1'b0;
      mul_en    = 1'b0;
      acc_en    = 1'b0;
      acc_clr   = 1'b0;
      acc_done  = 1'b0;
      adj_we    = 1'b0;
      det_we    = 1'b0;
      res_we    = 1'b0;
      res_widx  = step_ff;
      res_wdata = div_value;
      div_load  = 1'b0;
      div_step  = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid && pop_data.start) begin
               state_in = BK_ADJ;
               step_in  = '0;
               term_in  = '0;
               phase_in = PH_ADDR;
               acc_clr  = 1'b1;
            end
         end
         BK_ADJ, BK_DET, BK_TRN: begin
            unique case (phase_ff)
               PH_ADDR: phase_in = PH_MUL;
               PH_MUL: begin
                  mul_en   = 1'b1;
                  phase_in = PH_ACC;
               end
               default: begin
                  acc_en   = 1'b1;
                  phase_in = PH_ADDR;
                  term_in  = term_ff + 1'b1;
                  if (last_term) begin
                     term_in = '0;
                     step_in = step_ff + 1'b1;
                     if (state_ff == BK_ADJ) begin
                        adj_we   = 1'b1;
                        acc_done = 1'b1;
                        if (step_ff == index_type'(ADJ_COUNT - 1)) begin
                           state_in = BK_DET;
                           step_in  = '0;
                        end
                     end else if (state_ff == BK_DET) begin
                        if (step_ff == 4'd2) begin
                           det_we   = 1'b1;
                           acc_done = 1'b1;
                           state_in = BK_CHECK;
                        end
                     end else begin
                        res_we    = 1'b1;
                        res_widx  = index_type'(LAST_INDEX - 2) + step_ff;
                        res_wdata = trn_value;
                        acc_done  = 1'b1;
                        if (step_ff == 4'd2) begin
                           state_in = BK_EMIT;
                           step_in  = '0;
                        end
                     end
                  end
               end
            endcase
         end
         BK_CHECK: begin
            step_in = '0;
            if (sing_now) begin
               state_in = BK_EMIT;
            end else begin
               state_in = BK_DIV;
               div_load = 1'b1;
            end
         end
         BK_DIV: begin
            div_step = 1'b1;
            if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
               res_we = 1'b1;
               if (step_ff == index_type'(ADJ_COUNT - 1)) begin
                  state_in = BK_TRN;
                  step_in  = '0;
                  term_in  = '0;
                  phase_in = PH_ADDR;
                  acc_clr  = 1'b1;
               end else begin
                  step_in  = step_ff + 1'b1;
                  div_load = 1'b1;
               end
            end
         end
         BK_EMIT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_load = 1'b1;
               step_in  = step_ff + 1'b1;
               if (step_ff == index_type'(LAST_INDEX)) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= '0;
         term_ff      <= '0;
         phase_ff     <= PH_ADDR;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         term_ff  <= term_in;
         phase_ff <= phase_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         elem_mem[pop_data.index] <= pop_data.value;
      end
      rd_a_ff <= elem_mem[addr_a];
      rd_b_ff <= elem_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= op_a * op_b;
      end
      if (acc_clr || (acc_en && acc_done)) begin
         acc_ff <= '0;
      end else if (acc_en) begin
         acc_ff <= acc_sum;
      end
      if (adj_we) begin
         adj_ff[step_ff] <= acc_sum[ADJ_W-1:0];
      end
      if (det_we) begin
         det_neg_ff <= acc_sum[ACC_W-1];
         det_mag_ff <= acc_sum[ACC_W-1] ? MAG_W'(-acc_sum) : MAG_W'(acc_sum);
      end
      if (state_ff == BK_CHECK) begin
         sing_ff <= sing_now;
      end
      if (res_we) begin
         res_ff[res_widx] <= res_wdata;
      end
      if (div_load) begin
         num_ff     <= {adj_abs, {(2 * FRAC_BITS){1'b0}}};
         rem_ff     <= '0;
         quo_ff     <= '0;
         ovf_ff     <= 1'b0;
         cnt_ff     <= '0;
         div_neg_ff <= adj_rd[ADJ_W-1] ^ det_neg_ff;
      end else if (div_step) begin
         num_ff <= num_ff << 1;
         rem_ff <= rem_next[MAG_W-1:0];
         quo_ff <= quo_next;
         ovf_ff <= ovf_next;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (out_load) begin
         out_value_ff <= sing_ff ? '0 : res_ff[step_ff];
         out_index_ff <= step_ff;
         out_sing_ff  <= sing_ff;
         out_last_ff  <= step_ff == index_type'(LAST_INDEX);
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.out_value = out_value_ff;
   assign rsp.out_index = out_index_ff;
   assign rsp.singular  = out_sing_ff;
   assign rsp.last      = out_last_ff;

endmodule

### rtl/affine_matrix_inverse_top.sv
// Channel   Dir  Handshake      Payload
// req_bus   in   valid/ready    elem_value, elem_index
// rsp_bus   out  valid/ready    out_value, out_index, singular, last
// APB       in   psel/penable   singular_epsilon at byte address 0
//
// Element beats enter a 4-entry queue that lets loading run ahead of the math.
// A run (index 11) computes the cofactors and the determinant, then, unless the matrix
// is singular, nine 96-step restoring divisions and the translation; 12 beats go out.
// The 33x33 multiplier is shared, and the divider makes one quotient bit per cycle.
// Reset is synchronous; it clears control state and sets epsilon to 1.
// A stalled rsp_bus holds its beat in the output register while the sequencer waits.
module affine_matrix_inverse_top (
   input  logic                                 clock,
   input  logic                                 reset,
   aminv_req_if.sink                            req_bus,
   aminv_rsp_if.source                          rsp_bus,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [aminv_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import aminv_pkg::*;

   logic [EPS_W-1:0] eps_ff;
   logic             push_valid, push_ready, pop_valid, pop_ready;
   elem_type         push_data, pop_data;

   assign pready = 1'b1;
   assign prdata = (paddr == REG_SINGULAR_EPSILON) ? {{(32-EPS_W){1'b0}}, eps_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (psel && penable && pwrite && paddr == REG_SINGULAR_EPSILON) begin
         eps_ff <= pwdata[EPS_W-1:0];
      end
   end

   aminv_front u_front (
      .req        (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   aminv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   aminv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .epsilon   (eps_ff),
      .rsp       (rsp_bus)
   );

endmodule

### rtl/aminv_checker.sv
module aminv_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [aminv_pkg::VALUE_W-1:0]   rsp_value,
   input logic [aminv_pkg::INDEX_W-1:0]   rsp_index,
   input logic                            rsp_singular,
   input logic                            rsp_last
);
   import aminv_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_index))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_index == index_type'(LAST_INDEX))
      else $error("last mark on a beat other than the final element");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_value == '0)
      else $error("singular beat carries a nonzero value");

endmodule

bind affine_matrix_inverse_top aminv_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_value    (rsp_bus.out_value),
   .rsp_index    (rsp_bus.out_index),
   .rsp_singular (rsp_bus.singular),
   .rsp_last     (rsp_bus.last)
);

### dv/tb_top.sv
module tb_top;
   import aminv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      value_type value;
      index_type index;
   } elem_beat_type;

   typedef struct {
      value_type value;
      index_type index;
      logic      singular;
      logic      last;
   } inv_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   aminv_req_if req_bus ();
   aminv_rsp_if rsp_bus ();

   affine_matrix_inverse_top dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   always #4 clock = ~clock;

   elem_beat_type pending_elems[$];
   inv_beat_type  expected_inv[$];
   int unsigned beats_sent = 0;
   int unsigned total_queued = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   logic stall_long = 1'b0;

   // Predictor state
   logic signed [31:0] elem_mem[12];
   logic [15:0]        epsilon = 16'd1;

   function automatic logic signed [31:0] sat32(input logic signed [159:0] v);
      if (v > 160'sd2147483647) return 32'sh7fffffff;
      if (v < -160'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Accepts one element beat and, when it closes a matrix, queues the inverse.
   function automatic void predict_inverse(input elem_beat_type b);
      logic signed [159:0] e[12];
      logic signed [159:0] adj[9];
      logic signed [159:0] det, dmag, q, acc, amag;
      logic signed [31:0]  res[12];
      logic sing;
      inv_beat_type r;
      if (b.index > 4'd11) return;
      elem_mem[b.index] = b.value;
      if (b.index != 4'd11) return;
      for (int k = 0; k < 12; k++) e[k] = elem_mem[k];
      adj[0] = e[4]*e[8] - e[5]*e[7];
      adj[1] = e[2]*e[7] - e[1]*e[8];
      adj[2] = e[1]*e[5] - e[2]*e[4];
      adj[3] = e[5]*e[6] - e[3]*e[8];
      adj[4] = e[0]*e[8] - e[2]*e[6];
      adj[5] = e[2]*e[3] - e[0]*e[5];
      adj[6] = e[3]*e[7] - e[4]*e[6];
      adj[7] = e[1]*e[6] - e[0]*e[7];
      adj[8] = e[0]*e[4] - e[1]*e[3];
      det = e[0]*adj[0] + e[1]*adj[3] + e[2]*adj[6];
      dmag = det < 0 ? -det : det;
      sing = dmag <= ($signed({144'd0, epsilon}) <<< (2*FRAC_BITS));
      for (int k = 0; k < 12; k++) res[k] = '0;
      if (!sing) begin
         for (int k = 0; k < 9; k++) begin
            amag = adj[k] < 0 ? -adj[k] : adj[k];
            q = (amag <<< (2*FRAC_BITS)) / dmag;
            res[k] = sat32(((adj[k] < 0) != (det < 0)) ? -q : q);
         end
         for (int j = 0; j < 3; j++) begin
            acc = -(e[9]*res[j] + e[10]*res[3+j] + e[11]*res[6+j]);
            amag = acc < 0 ? -acc : acc;
            amag = amag >>> FRAC_BITS;
            res[9+j] = sat32(acc < 0 ? -amag : amag);
         end
      end
      for (int k = 0; k < 12; k++) begin
         r.value = res[k];
         r.index = index_type'(k);
         r.singular = sing;
         r.last = (k == 11);
         expected_inv.push_back(r);
      end
   endfunction

   // Driver: the head of pending_elems is the beat on the bus while valid is high.
   int unsigned src_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.elem_value <= '0;
         req_bus.elem_index <= '0;
         src_wait <= $urandom_range(0, 18);
      end else if (req_bus.valid && !req_bus.ready) begin
      end else begin
         if (req_bus.valid) begin
            beats_sent <= beats_sent + 1;
            predict_inverse(pending_elems.pop_front());
         end
         if (src_wait != 0) begin
            src_wait <= src_wait - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_elems.size() > 0) begin
            req_bus.valid <= 1'b1;
            req_bus.elem_value <= pending_elems[0].value;
            req_bus.elem_index <= pending_elems[0].index;
            src_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Monitor and response stall control
   int unsigned sink_wait = 0;
   inv_beat_type exp_beat;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_inv.size() == 0) begin
               $error("unexpected beat index=%0d value=%0h", rsp_bus.out_index,
                      rsp_bus.out_value);
               fail_count <= fail_count + 1;
            end else begin
               exp_beat = expected_inv.pop_front();
               if (rsp_bus.out_value !== exp_beat.value) begin
                  $error("out_value exp %0h got %0h", exp_beat.value, rsp_bus.out_value);
                  fail_count <= fail_count + 1;
               end
               if (rsp_bus.out_index !== exp_beat.index) begin
                  $error("out_index exp %0d got %0d", exp_beat.index, rsp_bus.out_index);
                  fail_count <= fail_count + 1;
               end
               if (rsp_bus.singular !== exp_beat.singular) begin
                  $error("singular exp %0b got %0b", exp_beat.singular, rsp_bus.singular);
                  fail_count <= fail_count + 1;
               end
               if (rsp_bus.last !== exp_beat.last) begin
                  $error("last exp %0b got %0b", exp_beat.last, rsp_bus.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (stall_long) begin
            rsp_bus.ready <= 1'b0;
         end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_bus.valid && rsp_bus.ready && $urandom_range(0, 2) == 0)
               sink_wait <= $urandom_range(0, 18);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > 3000000) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic queue_elem(input value_type v, input index_type i);
      elem_beat_type b;
      b.value = v;
      b.index = i;
      pending_elems.push_back(b);
      total_queued++;
   endtask

   task automatic queue_matrix(input value_type m[12]);
      for (int k = 0; k < 12; k++) queue_elem(m[k], index_type'(k));
   endtask

   task automatic drain_all();
      while (beats_sent != total_queued || expected_inv.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] a, input logic [31:0] d);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (a == REG_SINGULAR_EPSILON) epsilon = d[15:0];
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic value_type rand_value();
      case ($urandom_range(0, 5))
         0: return value_type'($urandom);
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         default: return value_type'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      endcase
   endfunction

   function automatic void fill_random(output value_type m[12]);
      for (int k = 0; k < 12; k++) m[k] = rand_value();
      if ($urandom_range(0, 4) == 0) begin
         for (int c = 0; c < 3; c++) m[6+c] = m[c];  // repeated row, determinant zero
      end
   endfunction

   initial begin
      value_type m[12];
      int unsigned n;
      for (int k = 0; k < 12; k++) elem_mem[k] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity, extremes, out-of-range index, repeat-compute and singular cases.
      m = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000,
            32'sh30000, -32'sh20000, 32'sh8000};
      queue_matrix(m);
      m = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1, 32'sh7fffffff, 32'sh80000000, 5, 3,
            32'sh7fffffff, 32'sh80000000, -1};
      queue_matrix(m);
      queue_elem(32'sh1234, 4'd12);
      queue_elem(32'sh1234, 4'd15);
      queue_elem(32'sh1, 4'd11);                  // recompute with held elements
      m = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 3};
      queue_matrix(m);
      drain_all();

      csr_write(REG_SINGULAR_EPSILON, 32'd0);
      m = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 32'sh7fffffff, 32'sh80000000, 0};
      queue_matrix(m);
      drain_all();
      csr_write(REG_SINGULAR_EPSILON, 32'd65535);
      queue_matrix(m);
      m = '{32'sh1000000, 0, 0, 0, 32'sh1000000, 0, 0, 0, 32'sh1000000, 0, 0, 1};
      queue_matrix(m);
      drain_all();
      csr_write(REG_SINGULAR_EPSILON, 32'd1);

      // Long receiver stall while the sender keeps going.
      stall_long = 1'b1;
      for (int i = 0; i < 3; i++) begin
         fill_random(m);
         queue_matrix(m);
      end
      repeat (4000) @(posedge clock);
      stall_long = 1'b0;
      drain_all();

      n = 0;
      while (n < 360) begin
         if (n % 120 == 0 && n != 0) begin
            drain_all();
            csr_write(REG_SINGULAR_EPSILON, $urandom_range(0, 65535));
         end
         if ($urandom_range(0, 9) == 0) begin
            queue_elem(rand_value(), index_type'($urandom_range(0, 15)));
            n++;
         end else begin
            fill_random(m);
            queue_matrix(m);
            n += 12;
         end
      end
      queue_elem(rand_value(), 4'd11);
      drain_all();
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
